@@ hdl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Item types, opcodes, status codes and saturation helpers shared by the
// front, the back and the step stages.
// ----------------------------------------------------------------------------
package cau_pkg;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_MAG,
      OP_CONJ,
      OP_NEG,
      OP_EQ
   } op_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned STEPS       = 32;

   typedef enum logic [1:0] {
      KIND_DONE,
      KIND_MUL,
      KIND_DIV,
      KIND_MAG
   } kind_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic               is_equal;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      kind_type kind;
      req_type  req;
      rsp_type  rsp;
   } entry_type;

   typedef struct packed {
      kind_type kind;
      logic     neg_re;
      logic     neg_im;
      logic     big_re;
      logic     big_im;
      rsp_type  rsp;
   } tag_type;

   typedef struct packed {
      logic [63:0] r_re;
      logic [63:0] r_im;
      logic [31:0] bits_re;
      logic [31:0] bits_im;
      logic [31:0] q_re;
      logic [31:0] q_im;
      logic [63:0] d;
      logic [33:0] rt_rem;
      logic [31:0] rt_q;
      logic [63:0] rt_x;
   } step_type;

   typedef struct packed {
      logic        ovf;
      logic [31:0] val;
   } sat_type;

   function automatic sat_type sat32(input logic neg, input logic [63:0] m);
      sat_type s;
      s.ovf = 1'b0;
      if (!neg) begin
         if (m > 64'h0000_0000_7FFF_FFFF) begin
            s.ovf = 1'b1;
            s.val = 32'h7FFF_FFFF;
         end else begin
            s.val = m[31:0];
         end
      end else begin
         if (m > 64'h0000_0000_8000_0000) begin
            s.ovf = 1'b1;
            s.val = 32'h8000_0000;
         end else begin
            s.val = 32'd0 - m[31:0];
         end
      end
      return s;
   endfunction

   function automatic sat_type sat_s33(input logic signed [32:0] v);
      logic [32:0] m;
      m = v[32] ? 33'(-v) : 33'(v);
      return sat32(v[32], {31'd0, m});
   endfunction

endpackage

@@ hdl/cau_step.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit step stage
// One quotient bit for each of the two divide lanes and one root bit for the
// square root lane, registered, with a shared advance.
// ----------------------------------------------------------------------------
module cau_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  cau_pkg::tag_type  in_tag,
   input  cau_pkg::step_type in_step,
   output logic              out_valid,
   output cau_pkg::tag_type  out_tag,
   output cau_pkg::step_type out_step
);

   logic              valid_ff;
   cau_pkg::tag_type  tag_ff;
   cau_pkg::step_type step_ff;
   cau_pkg::step_type step_in;

   logic [64:0] r2_re;
   logic [64:0] r2_im;
   logic [64:0] dx;
   logic        ge_re;
   logic        ge_im;
   logic [35:0] rt_t;
   logic [35:0] rt_trial;
   logic        rt_ge;

   always_comb begin
      dx    = {1'b0, in_step.d};
      r2_re = {in_step.r_re, in_step.bits_re[31]};
      r2_im = {in_step.r_im, in_step.bits_im[31]};
      ge_re = r2_re >= dx;
      ge_im = r2_im >= dx;

      rt_t     = {in_step.rt_rem, in_step.rt_x[63:62]};
      rt_trial = {2'b00, in_step.rt_q, 2'b01};
      rt_ge    = rt_t >= rt_trial;

      step_in         = in_step;
      step_in.r_re    = ge_re ? 64'(r2_re - dx) : r2_re[63:0];
      step_in.r_im    = ge_im ? 64'(r2_im - dx) : r2_im[63:0];
      step_in.bits_re = {in_step.bits_re[30:0], 1'b0};
      step_in.bits_im = {in_step.bits_im[30:0], 1'b0};
      step_in.q_re    = {in_step.q_re[30:0], ge_re};
      step_in.q_im    = {in_step.q_im[30:0], ge_im};
      step_in.rt_rem  = rt_ge ? 34'(rt_t - rt_trial) : rt_t[33:0];
      step_in.rt_q    = {in_step.rt_q[30:0], rt_ge};
      step_in.rt_x    = {in_step.rt_x[61:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff  <= in_tag;
         step_ff <= step_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_step  = step_ff;

endmodule

@@ hdl/cau_front.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit front
// Accepts items, finishes the simple operations at once, marks the rest for
// the back and holds every item in a short queue.
// ----------------------------------------------------------------------------
module cau_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  cau_pkg::req_type   req_data,
   output logic               q_valid,
   output cau_pkg::entry_type q_head,
   input  logic               q_pop
);

   cau_pkg::entry_type            mem_ff [cau_pkg::QUEUE_DEPTH];
   logic [cau_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [cau_pkg::QPTR_W-1:0]    wr_ptr_in;
   logic [cau_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [cau_pkg::QPTR_W-1:0]    rd_ptr_in;
   logic [cau_pkg::QPTR_W:0]      count_ff;
   logic [cau_pkg::QPTR_W:0]      count_in;
   logic                          wr;

   cau_pkg::entry_type ent;
   logic signed [32:0] v_re;
   logic signed [32:0] v_im;
   cau_pkg::sat_type   s_re;
   cau_pkg::sat_type   s_im;

   always_comb begin
      v_re     = '0;
      v_im     = '0;
      ent.kind = cau_pkg::KIND_DONE;
      ent.req  = req_data;
      ent.rsp  = '0;
      unique case (req_data.op)
         cau_pkg::OP_ADD: begin
            v_re = 33'(req_data.a_re) + 33'(req_data.b_re);
            v_im = 33'(req_data.a_im) + 33'(req_data.b_im);
         end
         cau_pkg::OP_SUB: begin
            v_re = 33'(req_data.a_re) - 33'(req_data.b_re);
            v_im = 33'(req_data.a_im) - 33'(req_data.b_im);
         end
         cau_pkg::OP_MUL:  ent.kind = cau_pkg::KIND_MUL;
         cau_pkg::OP_DIV:  ent.kind = cau_pkg::KIND_DIV;
         cau_pkg::OP_MAG:  ent.kind = cau_pkg::KIND_MAG;
         cau_pkg::OP_CONJ: begin
            v_re = 33'(req_data.a_re);
            v_im = -33'(req_data.a_im);
         end
         cau_pkg::OP_NEG: begin
            v_re = -33'(req_data.a_re);
            v_im = -33'(req_data.a_im);
         end
         cau_pkg::OP_EQ: begin
            ent.rsp.is_equal = (req_data.a_re == req_data.b_re) &&
                               (req_data.a_im == req_data.b_im);
         end
      endcase
      s_re           = cau_pkg::sat_s33(v_re);
      s_im           = cau_pkg::sat_s33(v_im);
      ent.rsp.res_re = s_re.val;
      ent.rsp.res_im = s_im.val;
      ent.rsp.status = (s_re.ovf || s_im.ovf) ? cau_pkg::STATUS_OVERFLOW
                                              : cau_pkg::STATUS_OK;
   end

   assign req_full = (count_ff == (cau_pkg::QPTR_W+1)'(cau_pkg::QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_head   = mem_ff[rd_ptr_ff];
   assign wr       = req_push && !req_full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (wr && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!wr && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= ent;
      end
   end

endmodule

@@ hdl/cau_back.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit back
// Multiply, sum, magnitude and setup stages, a chain of step stages for the
// quotients and the root, and the output register.
// ----------------------------------------------------------------------------
module cau_back #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  cau_pkg::entry_type q_head,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output cau_pkg::rsp_type   rsp_data
);

   logic adv;

   // multiply stage
   logic               v1_ff;
   cau_pkg::tag_type   tag1_ff;
   logic signed [63:0] prr_ff;
   logic signed [63:0] pii_ff;
   logic signed [63:0] pri_ff;
   logic signed [63:0] pir_ff;
   logic [63:0]        sq0_ff;
   logic [63:0]        sq1_ff;
   cau_pkg::tag_type   tag1_in;
   logic signed [31:0] sq_x;
   logic signed [31:0] sq_y;

   // sum stage
   logic               v2_ff;
   cau_pkg::tag_type   tag2_ff;
   logic signed [64:0] sr2_ff;
   logic signed [64:0] si2_ff;
   logic [63:0]        d2_ff;
   logic signed [64:0] sr2_in;
   logic signed [64:0] si2_in;

   // magnitude stage
   logic               v3_ff;
   cau_pkg::tag_type   tag3_ff;
   logic [63:0]        mr3_ff;
   logic [63:0]        mi3_ff;
   logic [63:0]        d3_ff;
   cau_pkg::tag_type   tag3_in;
   logic [64:0]        mr3_in;
   logic [64:0]        mi3_in;

   // setup stage
   logic               v4_ff;
   cau_pkg::tag_type   tag4_ff;
   cau_pkg::step_type  step4_ff;
   cau_pkg::tag_type   tag4_in;
   cau_pkg::step_type  step4_in;
   logic [63:0]        r0_re;
   logic [63:0]        r0_im;
   logic [63:0]        sh_re;
   logic [63:0]        sh_im;
   cau_pkg::sat_type   ms_re;
   cau_pkg::sat_type   ms_im;

   logic              stg_valid [cau_pkg::STEPS+1];
   cau_pkg::tag_type  stg_tag   [cau_pkg::STEPS+1];
   cau_pkg::step_type stg_step  [cau_pkg::STEPS+1];

   // output
   logic               out_valid_ff;
   cau_pkg::rsp_type   out_ff;
   cau_pkg::rsp_type   out_in;
   cau_pkg::tag_type   ft;
   cau_pkg::step_type  fs;
   cau_pkg::sat_type   fq_re;
   cau_pkg::sat_type   fq_im;

   assign adv   = !out_valid_ff || rsp_pop;
   assign q_pop = adv && q_valid;

   always_comb begin
      tag1_in.kind   = q_head.kind;
      tag1_in.neg_re = 1'b0;
      tag1_in.neg_im = 1'b0;
      tag1_in.big_re = 1'b0;
      tag1_in.big_im = 1'b0;
      tag1_in.rsp    = q_head.rsp;
      sq_x = (q_head.kind == cau_pkg::KIND_MAG) ? q_head.req.a_re : q_head.req.b_re;
      sq_y = (q_head.kind == cau_pkg::KIND_MAG) ? q_head.req.a_im : q_head.req.b_im;
   end

   always_comb begin
      if (tag1_ff.kind == cau_pkg::KIND_DIV) begin
         sr2_in = 65'(prr_ff) + 65'(pii_ff);
         si2_in = 65'(pir_ff) - 65'(pri_ff);
      end else begin
         sr2_in = 65'(prr_ff) - 65'(pii_ff);
         si2_in = 65'(pri_ff) + 65'(pir_ff);
      end
   end

   always_comb begin
      tag3_in        = tag2_ff;
      tag3_in.neg_re = sr2_ff[64];
      tag3_in.neg_im = si2_ff[64];
      mr3_in         = sr2_ff[64] ? 65'(-sr2_ff) : 65'(sr2_ff);
      mi3_in         = si2_ff[64] ? 65'(-si2_ff) : 65'(si2_ff);
   end

   always_comb begin
      r0_re = mr3_ff >> (32 - FRAC_BITS);
      r0_im = mi3_ff >> (32 - FRAC_BITS);
      sh_re = mr3_ff << FRAC_BITS;
      sh_im = mi3_ff << FRAC_BITS;
      ms_re = cau_pkg::sat32(tag3_ff.neg_re, mr3_ff >> FRAC_BITS);
      ms_im = cau_pkg::sat32(tag3_ff.neg_im, mi3_ff >> FRAC_BITS);

      step4_in.r_re    = r0_re;
      step4_in.r_im    = r0_im;
      step4_in.bits_re = sh_re[31:0];
      step4_in.bits_im = sh_im[31:0];
      step4_in.q_re    = '0;
      step4_in.q_im    = '0;
      step4_in.d       = d3_ff;
      step4_in.rt_rem  = '0;
      step4_in.rt_q    = '0;
      step4_in.rt_x    = d3_ff;

      tag4_in        = tag3_ff;
      tag4_in.big_re = r0_re >= d3_ff;
      tag4_in.big_im = r0_im >= d3_ff;
      if (tag3_ff.kind == cau_pkg::KIND_MUL) begin
         tag4_in.kind            = cau_pkg::KIND_DONE;
         tag4_in.rsp.res_re      = ms_re.val;
         tag4_in.rsp.res_im      = ms_im.val;
         tag4_in.rsp.is_equal    = 1'b0;
         tag4_in.rsp.status      = (ms_re.ovf || ms_im.ovf) ? cau_pkg::STATUS_OVERFLOW
                                                            : cau_pkg::STATUS_OK;
      end else if (tag3_ff.kind == cau_pkg::KIND_DIV && d3_ff == '0) begin
         tag4_in.kind            = cau_pkg::KIND_DONE;
         tag4_in.rsp.res_re      = '0;
         tag4_in.rsp.res_im      = '0;
         tag4_in.rsp.is_equal    = 1'b0;
         tag4_in.rsp.status      = cau_pkg::STATUS_DIV_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= q_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag1_ff  <= tag1_in;
         prr_ff   <= q_head.req.a_re * q_head.req.b_re;
         pii_ff   <= q_head.req.a_im * q_head.req.b_im;
         pri_ff   <= q_head.req.a_re * q_head.req.b_im;
         pir_ff   <= q_head.req.a_im * q_head.req.b_re;
         sq0_ff   <= 64'(sq_x * sq_x);
         sq1_ff   <= 64'(sq_y * sq_y);
         tag2_ff  <= tag1_ff;
         sr2_ff   <= sr2_in;
         si2_ff   <= si2_in;
         d2_ff    <= sq0_ff + sq1_ff;
         tag3_ff  <= tag3_in;
         mr3_ff   <= mr3_in[63:0];
         mi3_ff   <= mi3_in[63:0];
         d3_ff    <= d2_ff;
         tag4_ff  <= tag4_in;
         step4_ff <= step4_in;
      end
   end

   assign stg_valid[0] = v4_ff;
   assign stg_tag[0]   = tag4_ff;
   assign stg_step[0]  = step4_ff;

   for (genvar i = 0; i < cau_pkg::STEPS; i++) begin : g_step
      cau_step u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (stg_valid[i]),
         .in_tag    (stg_tag[i]),
         .in_step   (stg_step[i]),
         .out_valid (stg_valid[i+1]),
         .out_tag   (stg_tag[i+1]),
         .out_step  (stg_step[i+1])
      );
   end

   always_comb begin
      ft    = stg_tag[cau_pkg::STEPS];
      fs    = stg_step[cau_pkg::STEPS];
      fq_re = cau_pkg::sat32(ft.neg_re, ft.big_re ? '1 : {32'd0, fs.q_re});
      fq_im = cau_pkg::sat32(ft.neg_im, ft.big_im ? '1 : {32'd0, fs.q_im});
      out_in = ft.rsp;
      unique case (ft.kind)
         cau_pkg::KIND_DIV: begin
            out_in.res_re   = fq_re.val;
            out_in.res_im   = fq_im.val;
            out_in.is_equal = 1'b0;
            out_in.status   = (fq_re.ovf || fq_im.ovf) ? cau_pkg::STATUS_OVERFLOW
                                                       : cau_pkg::STATUS_OK;
         end
         cau_pkg::KIND_MAG: begin
            fq_re           = cau_pkg::sat32(1'b0, {32'd0, fs.rt_q});
            out_in.res_re   = fq_re.val;
            out_in.res_im   = '0;
            out_in.is_equal = 1'b0;
            out_in.status   = fq_re.ovf ? cau_pkg::STATUS_OVERFLOW : cau_pkg::STATUS_OK;
         end
         default: out_in = ft.rsp;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= stg_valid[cau_pkg::STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ hdl/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, magnitude, conjugate, negate and compare
// on complex operands in signed fixed point, with saturation.
// ----------------------------------------------------------------------------
// One item is taken per clock while the input queue is not full, and one
// result leaves per clock while results are popped. Every item passes
// through a four-entry input queue and a 37-stage pipeline (multiply, sum,
// magnitude, setup, 32 stages that each form one bit of both quotients and
// of the square root, output register). A result not popped holds the whole
// pipeline; the input queue keeps taking items until full.
module complex_arithmetic_unit #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cau_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cau_pkg::rsp_type rsp_data
);

   logic               q_valid;
   logic               q_pop;
   cau_pkg::entry_type q_head;

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   cau_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ test/complex_arithmetic_unit_test.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives opcode and operand items through the input queue, predicts every
// result in fixed point and compares each popped result in order. Random
// gaps on both sides, plus one long result hold-off that fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;

   localparam int unsigned FRAC = 16;
   localparam int unsigned N_RANDOM = 1800;
   localparam int unsigned STALL_LIMIT = 2000;

   class cau_scoreboard;
      cau_pkg::rsp_type pending[$];
      int unsigned mismatches;
      int unsigned checked;

      function automatic logic [63:0] mag64(input logic signed [63:0] v);
         return v[63] ? 64'(-v) : 64'(v);
      endfunction

      function automatic logic [31:0] clip(input logic neg, input logic [63:0] m,
                                           inout logic [1:0] st);
         if (!neg && m > 64'h7FFF_FFFF) begin
            st = cau_pkg::STATUS_OVERFLOW;
            return 32'h7FFF_FFFF;
         end
         if (neg && m > 64'h8000_0000) begin
            st = cau_pkg::STATUS_OVERFLOW;
            return 32'h8000_0000;
         end
         return neg ? 32'd0 - m[31:0] : m[31:0];
      endfunction

      // signed sum of two 64-bit values, as sign and magnitude truncated to 64 bits
      function automatic logic [63:0] sum_sm(input logic signed [63:0] x,
                                             input logic signed [63:0] y,
                                             output logic neg);
         logic signed [65:0] s;
         s = 66'(x) + 66'(y);
         neg = s[65];
         return neg ? 64'(-s) : 64'(s);
      endfunction

      function automatic logic [63:0] quot(input logic [63:0] m, input logic [63:0] d);
         logic [127:0] q;
         q = {m, {FRAC{1'b0}}} / 128'(d);
         return (q >> FRAC) >= (128'd1 << (32 - FRAC)) ? {64{1'b1}} : q[63:0];
      endfunction

      function automatic logic [63:0] root(input logic [63:0] x);
         logic [63:0] r;
         logic [127:0] t;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            t = 128'(r | (64'd1 << b));
            if (t * t <= 128'(x)) r = r | (64'd1 << b);
         end
         return r;
      endfunction

      function automatic cau_pkg::rsp_type predict(input cau_pkg::req_type q);
         cau_pkg::rsp_type r;
         logic signed [63:0] ar, ai, br, bi;
         logic [63:0] mr, mi, d;
         logic nr, ni;
         logic [1:0] st;
         ar = q.a_re;
         ai = q.a_im;
         br = q.b_re;
         bi = q.b_im;
         r = '0;
         st = cau_pkg::STATUS_OK;
         case (q.op)
            cau_pkg::OP_ADD: begin
               mr = sum_sm(ar, br, nr);
               mi = sum_sm(ai, bi, ni);
               r.res_re = clip(nr, mr, st);
               r.res_im = clip(ni, mi, st);
            end
            cau_pkg::OP_SUB: begin
               mr = sum_sm(ar, -br, nr);
               mi = sum_sm(ai, -bi, ni);
               r.res_re = clip(nr, mr, st);
               r.res_im = clip(ni, mi, st);
            end
            cau_pkg::OP_MUL: begin
               mr = sum_sm(ar * br, -(ai * bi), nr);
               mi = sum_sm(ar * bi, ai * br, ni);
               r.res_re = clip(nr, mr >> FRAC, st);
               r.res_im = clip(ni, mi >> FRAC, st);
            end
            cau_pkg::OP_DIV: begin
               d = 64'(br * br) + 64'(bi * bi);
               if (d == 0) begin
                  st = cau_pkg::STATUS_DIV_ZERO;
               end else begin
                  mr = sum_sm(ar * br, ai * bi, nr);
                  mi = sum_sm(ai * br, -(ar * bi), ni);
                  r.res_re = clip(nr, quot(mr, d), st);
                  r.res_im = clip(ni, quot(mi, d), st);
               end
            end
            cau_pkg::OP_MAG: begin
               r.res_re = clip(1'b0, root(64'(ar * ar) + 64'(ai * ai)), st);
            end
            cau_pkg::OP_CONJ: begin
               r.res_re = q.a_re;
               r.res_im = clip(~ai[63] && ai != 0, mag64(ai), st);
            end
            cau_pkg::OP_NEG: begin
               r.res_re = clip(~ar[63] && ar != 0, mag64(ar), st);
               r.res_im = clip(~ai[63] && ai != 0, mag64(ai), st);
            end
            default: r.is_equal = (ar == br) && (ai == bi);
         endcase
         r.status = st;
         return r;
      endfunction

      function void note_item(input cau_pkg::req_type q);
         pending.push_back(predict(q));
      endfunction

      function void check_result(input cau_pkg::rsp_type got);
         cau_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected re %h im %h eq %b st %0d, got re %h im %h eq %b st %0d",
                        want.res_re, want.res_im, want.is_equal, want.status,
                        got.res_re, got.res_im, got.is_equal, got.status);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   cau_pkg::req_type req_data;
   logic rsp_empty;
   logic rsp_pop;
   cau_pkg::rsp_type rsp_data;

   cau_scoreboard board;
   cau_pkg::req_type directed[$];
   bit feeding_done;
   bit hold_off;
   int unsigned idle_cycles;
   int unsigned n_items;
   int unsigned rx_gap;

   complex_arithmetic_unit #(.FRAC_BITS(FRAC)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3: return 32'($signed($urandom_range(0, 8)) - 4) << FRAC;
         4: return 32'($signed($urandom_range(0, 2000)) - 1000);
         5, 6: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000) << 4;
         default: return $urandom;
      endcase
   endfunction

   function automatic cau_pkg::req_type random_item();
      cau_pkg::req_type q;
      q.op = cau_pkg::op_type'($urandom_range(0, 7));
      q.a_re = pick_value();
      q.a_im = pick_value();
      q.b_re = pick_value();
      q.b_im = pick_value();
      if ($urandom_range(0, 9) == 0) begin
         q.b_re = '0;
         q.b_im = '0;
      end
      if (q.op == cau_pkg::OP_EQ && $urandom_range(0, 1)) begin
         q.b_re = q.a_re;
         q.b_im = $urandom_range(0, 3) == 0 ? q.a_im ^ (32'd1 << $urandom_range(0, 31))
                                            : q.a_im;
      end
      return q;
   endfunction

   function automatic cau_pkg::req_type make_item(input cau_pkg::op_type op,
                                                  input logic [31:0] ar,
                                                  input logic [31:0] ai,
                                                  input logic [31:0] br,
                                                  input logic [31:0] bi);
      cau_pkg::req_type q;
      q.op = op;
      q.a_re = ar;
      q.a_im = ai;
      q.b_re = br;
      q.b_im = bi;
      return q;
   endfunction

   task automatic send_item(input cau_pkg::req_type q);
      int unsigned gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (req_full);
      board.note_item(q);
      n_items++;
      @(negedge clock);
   endtask

   // sender
   initial begin
      board = new();
      req_push = 1'b0;
      req_data = '0;
      hold_off = 1'b0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int o = 0; o < 8; o++) begin
         directed.push_back(make_item(cau_pkg::op_type'(o), 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000));
         directed.push_back(make_item(cau_pkg::op_type'(o), 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h7FFF_FFFF));
      end
      directed.push_back(make_item(cau_pkg::OP_DIV, 32'h0003_0000, 32'h0001_0000,
                                   32'd0, 32'd0));
      directed.push_back(make_item(cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'd0));
      directed.push_back(make_item(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0002_0000,
                                   32'h0003_0000, 32'hFFFC_0000));
      directed.push_back(make_item(cau_pkg::OP_MUL, 32'h0001_8000, 32'hFFFF_0000,
                                   32'h0002_0000, 32'h0000_8000));
      directed.push_back(make_item(cau_pkg::OP_MAG, 32'h0003_0000, 32'h0004_0000,
                                   32'd0, 32'd0));
      directed.push_back(make_item(cau_pkg::OP_CONJ, 32'h1234_5678, 32'h8000_0000,
                                   32'd0, 32'd0));
      directed.push_back(make_item(cau_pkg::OP_EQ, 32'h0001_0000, 32'h0002_0000,
                                   32'h0001_0000, 32'h0002_0000));
      directed.push_back(make_item(cau_pkg::OP_EQ, 32'h0001_0000, 32'h0002_0000,
                                   32'h0001_0000, 32'h0002_0001));
      foreach (directed[k]) send_item(directed[k]);
      for (int k = 0; k < N_RANDOM; k++) begin
         if (k == 600) hold_off = 1'b1;
         send_item(random_item());
      end
      req_push <= 1'b0;
      feeding_done = 1'b1;
   end

   // receiver
   initial begin
      rsp_pop = 1'b0;
      @(negedge reset);
      forever begin
         rx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
         if (hold_off) begin
            rsp_pop <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end else if (rx_gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (rx_gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         board.check_result(rsp_data);
         @(negedge clock);
      end
   end

   // watchdog and end of run
   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results outstanding", board.pending.size());
            $display("complex_arithmetic_unit verification failed");
            $finish;
         end
         if (feeding_done && board.pending.size() == 0) begin
            repeat (60) @(posedge clock);
            if (!rsp_empty) board.check_result(rsp_data);
            $display("%0d items sent, %0d results checked across all eight operations,",
                     n_items, board.checked);
            $display("with saturation, divide by zero and a full-queue stall exercised");
            if (board.mismatches == 0 && board.pending.size() == 0)
               $display("complex_arithmetic_unit verification clean");
            else
               $display("complex_arithmetic_unit verification failed");
            $finish;
         end
      end
   end

endmodule

@@ sim.f @@
hdl/cau_pkg.sv
hdl/cau_step.sv
hdl/cau_front.sv
hdl/cau_back.sv
hdl/complex_arithmetic_unit.sv
test/complex_arithmetic_unit_test.sv
